FILE: src/psbb_pkg.sv
package psbb_pkg;

    // Store geometry: two byte-wide banks, even and odd byte addresses
    localparam int STORE_BYTES = 1024;
    localparam int ROW_COUNT   = STORE_BYTES / 2;
    localparam int ROW_W       = $clog2(ROW_COUNT);
    localparam int BYTE_IDX_W  = $clog2(STORE_BYTES);

    // Bit positions and bit length
    localparam int POS_W     = 14;
    localparam int BIT_LIMIT = STORE_BYTES * 8;

    // Register fields
    localparam int WIDTH_W = 4;
    localparam int CAP_W   = 14;
    localparam int CFG_W   = 14;

    // Register indexes
    localparam logic CFG_SYMBOL_WIDTH = 1'b0;
    localparam logic CFG_CAPACITY     = 1'b1;

    // Command codes
    localparam logic [2:0] FUNC_APPEND    = 3'd0;
    localparam logic [2:0] FUNC_READ      = 3'd1;
    localparam logic [2:0] FUNC_RESET_ALL = 3'd2;
    localparam logic [2:0] FUNC_RESET_RD  = 3'd3;
    localparam logic [2:0] FUNC_RESET_WR  = 3'd4;

    // Access to one bank
    typedef struct packed {
        logic             we;
        logic [ROW_W-1:0] waddr;
        logic [7:0]       wdata;
        logic             re;
        logic [ROW_W-1:0] raddr;
    } bank_req_t;

endpackage

FILE: src/psbb_bank.sv
module psbb_bank (
    input  logic                clk,
    input  psbb_pkg::bank_req_t req,
    output logic [7:0]          rdata
);
    import psbb_pkg::*;

    logic [7:0] mem [ROW_COUNT];
    logic [7:0] rdata_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            mem[req.waddr] <= req.wdata;
        end
    end

    // Registered read port; data holds until the next read
    always_ff @(posedge clk)
    begin
        if (req.re)
        begin
            rdata_reg <= mem[req.raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: src/packed_symbol_bit_buffer.sv
// Packed symbol buffer: symbols of 1 to 8 bits are appended and read back MSB
// first from a 1024-byte store split into an even and an odd byte bank, so the
// two bytes a symbol may straddle are read together. Every item reads both
// banks, then merges the symbol and writes back (or extracts it) and loads the
// result register; the next item is taken in the cycle after that. After reset
// the block clears all 512 rows of the store, one row of both banks per cycle,
// with in_stall high; configuration writes are taken throughout. A result
// waiting on out_stall holds the block in its merge step.
// Configuration should be written only while the block is idle.
module packed_symbol_bit_buffer (
    input  logic                           clk,
    input  logic                           rst_n,
    // Configuration
    input  logic                           cfg_we,
    input  logic                           cfg_index,
    input  logic [psbb_pkg::CFG_W-1:0]     cfg_data,
    // Command channel
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic [2:0]                     func,
    input  logic [7:0]                     symbol_in,
    // Result channel
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic                           accepted,
    output logic [7:0]                     symbol_out
);
    import psbb_pkg::*;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_EXEC
    } state_t;

    state_t             state_reg, state_next;
    logic [ROW_W-1:0]   clr_row_reg, clr_row_next;

    logic [WIDTH_W-1:0] symbol_width_reg;
    logic [CAP_W-1:0]   capacity_reg;

    logic [POS_W-1:0]   wpos_reg, wpos_next;
    logic [POS_W-1:0]   rpos_reg, rpos_next;

    // Item held between the read and write cycles
    logic [2:0]         func_reg, func_next;
    logic [7:0]         sym_reg, sym_next;
    logic               ok_reg, ok_next;
    logic [POS_W-1:0]   pos_reg, pos_next;
    logic [ROW_W-1:0]   even_row_reg, even_row_next;
    logic [ROW_W-1:0]   odd_row_reg, odd_row_next;

    logic               out_valid_reg, out_valid_next;
    logic               accepted_reg, accepted_next;
    logic [7:0]         symbol_out_reg, symbol_out_next;

    bank_req_t          even_req, odd_req;
    logic [7:0]         even_rdata, odd_rdata;

    // Effective width and bit length
    logic [WIDTH_W-1:0]          w;
    logic [CAP_W+WIDTH_W-1:0]    bit_prod;
    logic [POS_W-1:0]            bit_len;
    logic [7:0]                  mask8;

    // Issue-side decode
    logic [POS_W-1:0]            pos_sel;
    logic [POS_W:0]              pos_end;
    logic [BYTE_IDX_W-1:0]       byte_idx;
    logic [ROW_W-1:0]            row;
    logic                        is_access;

    // Merge-side decode
    logic [2:0]                  off;
    logic                        hi_odd;
    logic [4:0]                  shift;
    logic                        spans;
    logic [15:0]                 window;
    logic [15:0]                 win_mask;
    logic [15:0]                 merged;
    logic [7:0]                  extracted;
    logic [POS_W-1:0]            pos_adv;
    logic                        out_free;

    psbb_bank u_even (
        .clk   (clk),
        .req   (even_req),
        .rdata (even_rdata)
    );

    psbb_bank u_odd (
        .clk   (clk),
        .req   (odd_req),
        .rdata (odd_rdata)
    );

    // Clamp width to 1..8 and saturate the bit length at the store size
    always_comb
    begin
        if (symbol_width_reg == '0)
        begin
            w = WIDTH_W'(1);
        end
        else if (symbol_width_reg > WIDTH_W'(8))
        begin
            w = WIDTH_W'(8);
        end
        else
        begin
            w = symbol_width_reg;
        end
        bit_prod = capacity_reg * (CAP_W+WIDTH_W)'(w);
        if (bit_prod > (CAP_W+WIDTH_W)'(BIT_LIMIT))
        begin
            bit_len = POS_W'(BIT_LIMIT);
        end
        else
        begin
            bit_len = bit_prod[POS_W-1:0];
        end
        mask8 = 8'hFF >> (4'd8 - w);
    end

    // Decode the offered command
    always_comb
    begin
        is_access = (func == FUNC_APPEND) || (func == FUNC_READ);
        pos_sel   = (func == FUNC_APPEND) ? wpos_reg : rpos_reg;
        pos_end   = {1'b0, pos_sel} + (POS_W+1)'(w);
        byte_idx  = pos_sel[3 +: BYTE_IDX_W];
        row       = byte_idx[BYTE_IDX_W-1:1];
    end

    // Merge or extract within the two-byte window
    always_comb
    begin
        off       = pos_reg[2:0];
        hi_odd    = pos_reg[3];
        shift     = 5'd16 - {2'b00, off} - {1'b0, w};
        spans     = ({1'b0, off} + w) > WIDTH_W'(8);
        window    = hi_odd ? {odd_rdata, even_rdata} : {even_rdata, odd_rdata};
        win_mask  = {8'h00, mask8} << shift;
        merged    = (window & ~win_mask) | ({8'h00, sym_reg & mask8} << shift);
        extracted = 8'(window >> shift) & mask8;
        pos_adv   = pos_reg + POS_W'(w);
        out_free  = !out_valid_reg || !out_stall;
    end

    // Sequencer next state
    always_comb
    begin
        state_next      = state_reg;
        clr_row_next    = clr_row_reg;
        wpos_next       = wpos_reg;
        rpos_next       = rpos_reg;
        func_next       = func_reg;
        sym_next        = sym_reg;
        ok_next         = ok_reg;
        pos_next        = pos_reg;
        even_row_next   = even_row_reg;
        odd_row_next    = odd_row_reg;
        out_valid_next  = out_valid_reg;
        accepted_next   = accepted_reg;
        symbol_out_next = symbol_out_reg;
        even_req        = '0;
        odd_req         = '0;

        // Drop the result once it is transferred
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_CLEAR:
            begin
                even_req.we    = 1'b1;
                even_req.waddr = clr_row_reg;
                odd_req.we     = 1'b1;
                odd_req.waddr  = clr_row_reg;
                clr_row_next   = clr_row_reg + ROW_W'(1);
                if (clr_row_reg == ROW_W'(ROW_COUNT - 1))
                begin
                    state_next = ST_IDLE;
                end
            end

            ST_IDLE:
            begin
                if (in_valid)
                begin
                    func_next     = func;
                    sym_next      = symbol_in;
                    pos_next      = pos_sel;
                    ok_next       = is_access && (pos_end <= {1'b0, bit_len});
                    even_row_next = byte_idx[0] ? row + ROW_W'(1) : row;
                    odd_row_next  = row;
                    even_req.re    = 1'b1;
                    even_req.raddr = byte_idx[0] ? row + ROW_W'(1) : row;
                    odd_req.re     = 1'b1;
                    odd_req.raddr  = row;
                    state_next    = ST_EXEC;
                end
            end

            ST_EXEC:
            begin
                if (out_free)
                begin
                    accepted_next   = 1'b0;
                    symbol_out_next = 8'h00;
                    case (func_reg) inside
                        FUNC_APPEND:
                        begin
                            if (ok_reg)
                            begin
                                // Byte holding the first bit always written
                                even_req.we    = !hi_odd || spans;
                                even_req.waddr = even_row_reg;
                                even_req.wdata = hi_odd ? merged[7:0] : merged[15:8];
                                odd_req.we     = hi_odd || spans;
                                odd_req.waddr  = odd_row_reg;
                                odd_req.wdata  = hi_odd ? merged[15:8] : merged[7:0];
                                wpos_next      = pos_adv;
                                accepted_next  = 1'b1;
                            end
                        end
                        FUNC_READ:
                        begin
                            if (ok_reg)
                            begin
                                rpos_next       = pos_adv;
                                symbol_out_next = extracted;
                                accepted_next   = 1'b1;
                            end
                        end
                        FUNC_RESET_ALL:
                        begin
                            wpos_next     = '0;
                            rpos_next     = '0;
                            accepted_next = 1'b1;
                        end
                        FUNC_RESET_RD:
                        begin
                            rpos_next     = '0;
                            accepted_next = 1'b1;
                        end
                        FUNC_RESET_WR:
                        begin
                            wpos_next     = '0;
                            accepted_next = 1'b1;
                        end
                        default:
                        begin
                            accepted_next = 1'b0;
                        end
                    endcase
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Hold state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_CLEAR;
            clr_row_reg    <= '0;
            wpos_reg       <= '0;
            rpos_reg       <= '0;
            func_reg       <= '0;
            sym_reg        <= '0;
            ok_reg         <= 1'b0;
            pos_reg        <= '0;
            even_row_reg   <= '0;
            odd_row_reg    <= '0;
            out_valid_reg  <= 1'b0;
            accepted_reg   <= 1'b0;
            symbol_out_reg <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            clr_row_reg    <= clr_row_next;
            wpos_reg       <= wpos_next;
            rpos_reg       <= rpos_next;
            func_reg       <= func_next;
            sym_reg        <= sym_next;
            ok_reg         <= ok_next;
            pos_reg        <= pos_next;
            even_row_reg   <= even_row_next;
            odd_row_reg    <= odd_row_next;
            out_valid_reg  <= out_valid_next;
            accepted_reg   <= accepted_next;
            symbol_out_reg <= symbol_out_next;
        end
    end

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            symbol_width_reg <= WIDTH_W'(8);
            capacity_reg     <= CAP_W'(1024);
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_SYMBOL_WIDTH: symbol_width_reg <= cfg_data[WIDTH_W-1:0];
                CFG_CAPACITY:     capacity_reg     <= cfg_data[CAP_W-1:0];
                default:          ;
            endcase
        end
    end

    assign in_stall   = (state_reg != ST_IDLE);
    assign out_valid  = out_valid_reg;
    assign accepted   = accepted_reg;
    assign symbol_out = symbol_out_reg;

endmodule
